// ----- hw/rtl/flba_pkg.sv -----
// Shared types and constants for the free list block allocator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package flba_pkg;

	localparam int POOL_SLOTS_DEF = 1024;
	localparam int CHUNK_W        = 11;
	localparam int SLOT_FIELD_W   = 10;
	localparam int STATUS_W       = 3;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(64);

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED  = 3'd0,
		ST_RELEASED   = 3'd1,
		ST_NULL       = 3'd2,
		ST_OUT_OF_MEM = 3'd3,
		ST_NOT_CARVED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_POP   = 3'b010,
		S_CARVE = 3'b100
	} state_t;

endpackage

// ----- hw/rtl/flba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the free list links for the allocator.
`timescale 1ns / 1ps

module flba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/free_list_block_allocator.sv -----
// Free list block allocator: LIFO list of slots, head register plus link RAM.
// Release, null, out of memory and uncarved slot: result in the cycle after accept.
// Allocate from a nonempty list: result registered after a link RAM read in S_POP.
// Empty list: carve chunk_size slots (0 counts as 1), one link written per cycle.
// A new item is accepted in the cycle its predecessor's done strobe shows; the
// receiver cannot stall. Reset clears head, list, carve count and sets chunk_size
// to 64; the link RAM is not cleared, every link is written before it is read.
`timescale 1ns / 1ps

module free_list_block_allocator #(
	parameter int POOL_SLOTS = flba_pkg::POOL_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [flba_pkg::SLOT_FIELD_W-1:0] slot,
	input  logic                              slot_present,
	output logic                              done,
	output logic [flba_pkg::SLOT_FIELD_W-1:0] granted_slot,
	output logic [flba_pkg::STATUS_W-1:0]     status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [flba_pkg::CHUNK_W-1:0]      chunk_size
);

	import flba_pkg::*;

	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int LINK_W = $clog2(POOL_SLOTS + 1);
	localparam int CNT_W  = LINK_W;
	localparam int SUM_W  = ((CNT_W > CHUNK_W) ? CNT_W : CHUNK_W) + 1;

	localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_SLOTS);
	localparam logic [SUM_W-1:0]  POOL_SUM = SUM_W'(POOL_SLOTS);

	// control state
	state_t             state_q, state_d;
	logic [SLOT_W-1:0]  head_q, head_d;
	logic               empty_q, empty_d;
	logic [CNT_W-1:0]   carved_q, carved_d;
	logic [CHUNK_W-1:0] chunk_q;
	logic               done_q, done_d;

	// payload and carve sequencer
	logic [SLOT_W-1:0]       carve_addr_q, carve_addr_d;
	logic [SLOT_W-1:0]       carve_last_q, carve_last_d;
	logic [LINK_W-1:0]       carve_link_q, carve_link_d;
	logic [SLOT_FIELD_W-1:0] granted_q, granted_d;
	status_t                 status_q, status_d;

	// link RAM port
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic              ram_re;
	logic [LINK_W-1:0] ram_rdata;

	logic                           accept;
	logic [CHUNK_W-1:0]             chunk_n;
	logic [SUM_W-1:0]               carve_end;
	logic [SUM_W-1:0]               carve_last_w;
	logic                           carve_fits;
	logic                           slot_carved;
	logic [SLOT_W+SLOT_FIELD_W-1:0] slot_wide;
	logic [SLOT_W-1:0]              slot_idx;
	logic [LINK_W-1:0]              head_link;
	logic [SLOT_W-1:0]              grant_idx;
	logic [SLOT_W+SLOT_FIELD_W-1:0] grant_wide;

	assign accept       = start & ~busy;
	assign chunk_n      = (chunk_q == '0) ? CHUNK_W'(1) : chunk_q;
	assign carve_end    = SUM_W'(carved_q) + SUM_W'(chunk_n);
	assign carve_last_w = carve_end - SUM_W'(1);
	assign carve_fits   = (carve_end <= POOL_SUM);
	assign slot_carved  = (SUM_W'(slot) < SUM_W'(carved_q));
	assign slot_wide    = {{SLOT_W{1'b0}}, slot};
	assign slot_idx     = slot_wide[SLOT_W-1:0];
	assign head_link    = empty_q ? LINK_END : LINK_W'(head_q);
	assign grant_idx    = (state_q == S_POP) ? head_q : carve_last_q;
	assign grant_wide   = {{SLOT_FIELD_W{1'b0}}, grant_idx};

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		empty_d      = empty_q;
		carved_d     = carved_q;
		done_d       = 1'b0;
		carve_addr_d = carve_addr_q;
		carve_last_d = carve_last_q;
		carve_link_d = carve_link_q;
		granted_d    = '0;
		status_d     = status_q;
		ram_we       = 1'b0;
		ram_waddr    = carve_addr_q;
		ram_wdata    = carve_link_q;
		ram_re       = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!action) begin
						if (!empty_q) begin
							// fetch the link behind the head
							ram_re  = 1'b1;
							state_d = S_POP;
						end else if (!carve_fits) begin
							done_d   = 1'b1;
							status_d = ST_OUT_OF_MEM;
						end else begin
							carved_d     = carve_end[CNT_W-1:0];
							carve_addr_d = carved_q[SLOT_W-1:0];
							carve_last_d = carve_last_w[SLOT_W-1:0];
							carve_link_d = LINK_END;
							state_d      = S_CARVE;
						end
					end else if (!slot_present) begin
						done_d   = 1'b1;
						status_d = ST_NULL;
					end else if (!slot_carved) begin
						done_d   = 1'b1;
						status_d = ST_NOT_CARVED;
					end else begin
						// push onto the list
						ram_we    = 1'b1;
						ram_waddr = slot_idx;
						ram_wdata = head_link;
						head_d    = slot_idx;
						empty_d   = 1'b0;
						done_d    = 1'b1;
						status_d  = ST_RELEASED;
					end
				end
			end
			S_POP: begin
				if (ram_rdata >= LINK_END) begin
					empty_d = 1'b1;
					head_d  = '0;
				end else begin
					head_d = ram_rdata[SLOT_W-1:0];
				end
				granted_d = grant_wide[SLOT_FIELD_W-1:0];
				done_d    = 1'b1;
				status_d  = ST_ALLOCATED;
				state_d   = S_IDLE;
			end
			S_CARVE: begin
				if (carve_addr_q == carve_last_q) begin
					// the top slot of the chunk goes straight out
					if (carve_link_q == LINK_END) begin
						empty_d = 1'b1;
						head_d  = '0;
					end else begin
						empty_d = 1'b0;
						head_d  = carve_link_q[SLOT_W-1:0];
					end
					granted_d = grant_wide[SLOT_FIELD_W-1:0];
					done_d    = 1'b1;
					status_d  = ST_ALLOCATED;
					state_d   = S_IDLE;
				end else begin
					ram_we       = 1'b1;
					carve_link_d = LINK_W'(carve_addr_q);
					carve_addr_d = SLOT_W'(carve_addr_q + 1'b1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			empty_q  <= 1'b1;
			carved_q <= '0;
			chunk_q  <= CHUNK_RESET;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			empty_q  <= empty_d;
			carved_q <= carved_d;
			done_q   <= done_d;
			if (cfg_valid && cfg_ready) begin
				chunk_q <= chunk_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		carve_addr_q <= carve_addr_d;
		carve_last_q <= carve_last_d;
		carve_link_q <= carve_link_d;
		if (done_d) begin
			granted_q <= granted_d;
			status_q  <= status_d;
		end
	end

	flba_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign granted_slot = granted_q;
	assign status       = status_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- tb/sv/tb_free_list_block_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for free_list_block_allocator: directed and random
// allocate/release traffic checked against a free list predictor kept in the bench.
// Depends on flba_pkg and the allocator RTL.

module tb_free_list_block_allocator;
	import flba_pkg::*;

	localparam int   POOL        = POOL_SLOTS_DEF;
	localparam int   IDLE_LIMIT  = 5000;
	localparam int   PRINT_LIMIT = 50;
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef struct {
		logic [SLOT_FIELD_W-1:0] slot_idx;
		status_t                 code;
	} grant_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    action       = 1'b0;
	logic [SLOT_FIELD_W-1:0] slot         = '0;
	logic                    slot_present = 1'b0;
	logic                    cfg_valid    = 1'b0;
	logic [CHUNK_W-1:0]      chunk_size   = '0;
	logic                    busy;
	logic                    done;
	logic                    cfg_ready;
	logic [SLOT_FIELD_W-1:0] granted_slot;
	logic [STATUS_W-1:0]     status;

	free_list_block_allocator #(.POOL_SLOTS(POOL)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.slot         (slot),
		.slot_present (slot_present),
		.done         (done),
		.granted_slot (granted_slot),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.chunk_size   (chunk_size)
	);

	// free list as the bench sees it
	logic [CHUNK_W-1:0]      pool_chunk;
	logic [SLOT_FIELD_W-1:0] pool_head;
	bit                      pool_empty;
	int                      pool_carved;
	int                      pool_link [POOL];

	grant_t grants_due [$];
	int     held_slots [$];
	int     fail_count  = 0;
	int     burst_left  = 0;
	int     idle_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void report_error(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("ERROR at %0t ns: %s", $realtime, msg);
		fail_count++;
	endfunction

	function automatic void push_free(input int s);
		pool_link[s] = pool_empty ? POOL : int'(pool_head);
		pool_head = s[SLOT_FIELD_W-1:0];
		pool_empty = 1'b0;
	endfunction

	function automatic grant_t allocate_or_release(input logic act,
			input logic [SLOT_FIELD_W-1:0] s, input logic pres);
		grant_t r;
		int n;
		int nx;
		r.slot_idx = '0;
		r.code = ST_ALLOCATED;
		if (act == ACT_ALLOC) begin
			n = (pool_chunk == 0) ? 1 : int'(pool_chunk);
			if (pool_empty && pool_carved + n > POOL) begin
				r.code = ST_OUT_OF_MEM;
			end else begin
				// carve so that the highest slot of the chunk ends up at the head
				if (pool_empty) begin
					for (int k = pool_carved; k < pool_carved + n; k++)
						push_free(k);
					pool_carved += n;
				end
				r.slot_idx = pool_head;
				nx = pool_link[pool_head];
				if (nx >= POOL) begin
					pool_empty = 1'b1;
					pool_head = '0;
				end else begin
					pool_head = nx[SLOT_FIELD_W-1:0];
				end
			end
		end else if (!pres) begin
			r.code = ST_NULL;
		end else if (int'(s) >= pool_carved) begin
			r.code = ST_NOT_CARVED;
		end else begin
			push_free(int'(s));
			r.code = ST_RELEASED;
		end
		return r;
	endfunction

	task automatic send_item(input logic act, input logic [SLOT_FIELD_W-1:0] s,
			input logic pres);
		int gap;
		grant_t r;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if ($urandom_range(3) != 0)
				gap = $urandom_range(8, 1);
		end
		burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		slot         <= s;
		slot_present <= pres;
		do @(posedge clk); while (busy);
		r = allocate_or_release(act, s, pres);
		grants_due.push_back(r);
		if (r.code == ST_ALLOCATED)
			held_slots.push_back(int'(r.slot_idx));
	endtask

	task automatic write_chunk(input logic [CHUNK_W-1:0] v);
		start <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		cfg_valid  <= 1'b1;
		chunk_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_chunk = v;
	endtask

	task automatic request_slot();
		send_item(ACT_ALLOC, SLOT_FIELD_W'($urandom_range(1023)), 1'($urandom_range(1)));
	endtask

	task automatic drain_free_list();
		while (!pool_empty) request_slot();
	endtask

	// loose: also free arbitrary slots, which may free a slot twice
	task automatic random_request(input int alloc_pct, input bit loose);
		int r;
		int q;
		int idx;
		int s;
		r = $urandom_range(99);
		q = $urandom_range(99);
		if (r < alloc_pct) begin
			request_slot();
		end else if (q < 12) begin
			send_item(ACT_RELEASE, SLOT_FIELD_W'($urandom_range(1023)), 1'b0);
		end else if (q < 24 && pool_carved < POOL) begin
			send_item(ACT_RELEASE, SLOT_FIELD_W'($urandom_range(1023, pool_carved)), 1'b1);
		end else if (q < 34 && loose) begin
			send_item(ACT_RELEASE, SLOT_FIELD_W'($urandom_range(1023)), 1'b1);
		end else if (held_slots.size() > 0) begin
			idx = $urandom_range(held_slots.size() - 1);
			s = held_slots[idx];
			held_slots.delete(idx);
			send_item(ACT_RELEASE, s[SLOT_FIELD_W-1:0], 1'b1);
		end else begin
			request_slot();
		end
	endtask

	// reset chunk size, null and uncarved releases, first carve
	task automatic test_reset_defaults();
		send_item(ACT_RELEASE, 10'd0, 1'b1);
		send_item(ACT_RELEASE, 10'd1023, 1'b0);
		send_item(ACT_RELEASE, 10'd0, 1'b0);
		send_item(ACT_ALLOC, 10'd1023, 1'b1);
		send_item(ACT_RELEASE, 10'd1023, 1'b1);
		send_item(ACT_RELEASE, 10'd64, 1'b1);
		send_item(ACT_RELEASE, 10'd63, 1'b1);
		void'(held_slots.pop_front());
		request_slot();
		request_slot();
		send_item(ACT_RELEASE, 10'd62, 1'b1);
		void'(held_slots.pop_back());
		request_slot();
	endtask

	task automatic test_zero_chunk();
		int s;
		write_chunk('0);
		drain_free_list();
		repeat (3) request_slot();
		s = held_slots.pop_back();
		send_item(ACT_RELEASE, s[SLOT_FIELD_W-1:0], 1'b1);
		request_slot();
	endtask

	task automatic test_oversized_chunk();
		int s;
		write_chunk('1);
		drain_free_list();
		request_slot();
		write_chunk(CHUNK_W'(POOL + 1));
		request_slot();
		s = held_slots.pop_back();
		send_item(ACT_RELEASE, s[SLOT_FIELD_W-1:0], 1'b1);
		request_slot();
		write_chunk(CHUNK_W'(POOL));
		request_slot();
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < 3; p++) begin
			write_chunk(CHUNK_W'($urandom_range(96, 2)));
			repeat (40) random_request(55, 1'b0);
		end
	endtask

	task automatic test_pool_exhaustion();
		write_chunk(CHUNK_W'(97));
		while (!(pool_empty && pool_carved + 97 > POOL)) random_request(90, 1'b0);
		repeat (2) request_slot();
		// carve what is left one slot at a time
		write_chunk(CHUNK_W'(1));
		while (pool_carved < POOL) random_request(90, 1'b0);
		drain_free_list();
		request_slot();
	endtask

	// a double free corrupts the list for good, so this runs last
	task automatic test_double_release();
		int s;
		write_chunk(CHUNK_W'(3));
		if (held_slots.size() == 0)
			request_slot();
		s = held_slots.pop_back();
		send_item(ACT_RELEASE, s[SLOT_FIELD_W-1:0], 1'b1);
		send_item(ACT_RELEASE, s[SLOT_FIELD_W-1:0], 1'b1);
		repeat (3) request_slot();
		repeat (60) random_request(50, 1'b1);
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				report_error($sformatf("result with no item outstanding: slot %0d status %0d",
					granted_slot, status));
			end else begin
				want = grants_due.pop_front();
				if (granted_slot !== want.slot_idx)
					report_error($sformatf("granted_slot %0d, expected %0d",
						granted_slot, want.slot_idx));
				if (status !== want.code)
					report_error($sformatf("status %0d, expected %0d", status, want.code));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		pool_chunk  = CHUNK_RESET;
		pool_head   = '0;
		pool_empty  = 1'b1;
		pool_carved = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_chunk();
		test_oversized_chunk();
		test_random_mix();
		test_pool_exhaustion();
		test_double_release();
		start <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
